>>> src/superio_watchdog_timer_top_assert.svh
// Assertion macros shared by the watchdog checker.
// Each use stands on a line of its own and names a clock signal clk and a
// reset signal rst in the scope where it is used.
`ifndef SUPERIO_WATCHDOG_TIMER_TOP_ASSERT_SVH
`define SUPERIO_WATCHDOG_TIMER_TOP_ASSERT_SVH

// Property checked at every clock edge outside reset.
`define SWT_CHECK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Property checked at every clock edge, reset included.
`define SWT_CHECK_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> src/swt_pkg.sv
`timescale 1ns / 1ps

package swt_pkg;

  // Prescaler ratio for the minute unit and the device number of the watchdog.
  localparam int unsigned TICKS_PER_MINUTE = 60;
  localparam logic [7:0]  WATCHDOG_DEVICE  = 8'h08;

  // Width of the minute prescaler count, wide enough to hold TICKS_PER_MINUTE itself.
  localparam int unsigned PRESCALE_W = 6;

  // Operation codes of a request word.
  typedef enum logic [1:0] {
    OP_WRITE = 2'd0,
    OP_READ  = 2'd1,
    OP_TICK  = 2'd2,
    OP_NONE  = 2'd3
  } opcode_t;

  // Port codes.
  localparam logic PORT_INDEX = 1'b0;
  localparam logic PORT_DATA  = 1'b1;

  // Index port keys.
  localparam logic [7:0] KEY_OPEN  = 8'h55;
  localparam logic [7:0] KEY_CLOSE = 8'haa;

  // Register indexes.
  localparam logic [7:0] IDX_LDN     = 8'h07;
  localparam logic [7:0] IDX_ACTIVE  = 8'h30;
  localparam logic [7:0] IDX_EVENT   = 8'he2;
  localparam logic [7:0] IDX_UNIT    = 8'hf1;
  localparam logic [7:0] IDX_TIMEOUT = 8'hf2;
  localparam logic [7:0] IDX_IRQSEL  = 8'hf3;

  // Request word.
  typedef struct packed {
    logic [1:0] opcode;
    logic       port_select;
    logic [7:0] write_data;
  } req_t;

  // Result word.
  typedef struct packed {
    logic [7:0] read_data;
    logic       irq_fire;
    logic       reset_fire;
    logic [3:0] irq_line;
  } rsp_t;

endpackage

>>> src/superio_watchdog_timer_top.sv
// Watchdog of a super I/O chip behind an index port and a data port.
// Request channel (req_valid, req_stall, req): each word is a bus write, a
// bus read, a one-second tick or a no-op. Result channel (rsp_valid,
// rsp_stall, rsp): exactly one result word per request word, in order,
// carrying the read byte (0 for anything but a read), the expiry pulses
// and the selected interrupt line.
// A request word waits in the request register until the result register
// is free or leaving; then the watchdog state and timer update together
// with loading the result register, where its result word is shown.
// Throughput is one word per cycle while rsp_stall is low; the result
// and request registers let a new word enter while a finished result waits.
// When rsp_stall holds the result, the request register keeps its word and
// req_stall rises once that register is full, so nothing is lost.
// Reset clears both registers, closes configuration mode and clears all
// watchdog registers; the timer is off until activated with a nonzero timeout.
`timescale 1ns / 1ps

module superio_watchdog_timer_top import swt_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  output logic req_stall,
  input  req_t req,
  output logic rsp_valid,
  input  logic rsp_stall,
  output rsp_t rsp
);

  logic req_q_valid;
  req_t req_q;
  rsp_t core_rsp;
  logic advance;

  // The request register moves on when the result register is free or leaving.
  assign advance   = req_q_valid && (!rsp_valid || !rsp_stall);
  assign req_stall = req_q_valid && !advance;

  // Request register.
  always_ff @(posedge clk) begin
    if (rst) begin
      req_q_valid <= 1'b0;
    end else if (req_valid && !req_stall) begin
      req_q_valid <= 1'b1;
    end else if (advance) begin
      req_q_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (req_valid && !req_stall) begin
      req_q <= req;
    end
  end

  swt_core u_core (
    .clk  (clk),
    .rst  (rst),
    .step (advance),
    .req  (req_q),
    .rsp  (core_rsp)
  );

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (advance) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      rsp <= core_rsp;
    end
  end

endmodule

>>> src/swt_core.sv
`timescale 1ns / 1ps

module swt_core import swt_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic step,
  input  req_t req,
  output rsp_t rsp
);

  // Architectural state.
  logic                  config_open;
  logic [7:0]            reg_index;
  logic [7:0]            logical_device;
  logic                  timer_active;
  logic                  event_reboot;
  logic                  unit_seconds;
  logic [3:0]            irq_select;
  logic [7:0]            remaining_count;
  logic [PRESCALE_W-1:0] minute_prescale;

  logic                  config_open_next;
  logic [7:0]            reg_index_next;
  logic [7:0]            logical_device_next;
  logic                  timer_active_next;
  logic                  event_reboot_next;
  logic                  unit_seconds_next;
  logic [3:0]            irq_select_next;
  logic [7:0]            remaining_count_next;
  logic [PRESCALE_W-1:0] minute_prescale_next;

  logic                  wd_selected;
  logic [PRESCALE_W:0]   prescale_sum;
  logic                  count_dec;
  logic [7:0]            data_rd;
  logic [7:0]            read_data;
  logic                  irq_fire;
  logic                  reset_fire;

  assign wd_selected  = (logical_device == WATCHDOG_DEVICE);
  assign prescale_sum = {1'b0, minute_prescale} + (PRESCALE_W+1)'(1);

  // Data port read mux.
  always_comb begin
    data_rd = 8'h00;
    if (reg_index == IDX_LDN) begin
      data_rd = logical_device;
    end else if (wd_selected) begin
      case (reg_index)
        IDX_ACTIVE:  data_rd = {7'b0, timer_active};
        IDX_EVENT:   data_rd = {4'b0, event_reboot, 3'b0};
        IDX_UNIT:    data_rd = {unit_seconds, 7'b0};
        IDX_TIMEOUT: data_rd = remaining_count;
        IDX_IRQSEL:  data_rd = {irq_select, 4'b0};
        default:     data_rd = 8'h00;
      endcase
    end
  end

  // Next state and result for the word at hand.
  always_comb begin
    config_open_next     = config_open;
    reg_index_next       = reg_index;
    logical_device_next  = logical_device;
    timer_active_next    = timer_active;
    event_reboot_next    = event_reboot;
    unit_seconds_next    = unit_seconds;
    irq_select_next      = irq_select;
    remaining_count_next = remaining_count;
    minute_prescale_next = minute_prescale;
    count_dec            = 1'b0;
    read_data            = 8'h00;
    irq_fire             = 1'b0;
    reset_fire           = 1'b0;

    case (opcode_t'(req.opcode))
      OP_WRITE: begin
        if (req.port_select == PORT_INDEX) begin
          if (req.write_data == KEY_OPEN) begin
            config_open_next = 1'b1;
          end else if (config_open) begin
            if (req.write_data == KEY_CLOSE) begin
              config_open_next = 1'b0;
            end else begin
              reg_index_next = req.write_data;
            end
          end
        end else if (config_open) begin
          if (reg_index == IDX_LDN) begin
            logical_device_next = req.write_data;
          end else if (wd_selected) begin
            case (reg_index)
              IDX_ACTIVE: timer_active_next = req.write_data[0];
              IDX_EVENT:  event_reboot_next = req.write_data[3];
              IDX_UNIT:   unit_seconds_next = req.write_data[7];
              IDX_TIMEOUT: begin
                remaining_count_next = req.write_data;
                minute_prescale_next = '0;
              end
              IDX_IRQSEL: irq_select_next = req.write_data[7:4];
              default: ;
            endcase
          end
        end
      end
      OP_READ: begin
        if (config_open) begin
          read_data = (req.port_select == PORT_INDEX) ? reg_index : data_rd;
        end
      end
      OP_TICK: begin
        if (timer_active && (remaining_count != 8'h00)) begin
          if (unit_seconds) begin
            count_dec = 1'b1;
          end else if (prescale_sum >= (PRESCALE_W+1)'(TICKS_PER_MINUTE)) begin
            minute_prescale_next = '0;
            count_dec            = 1'b1;
          end else begin
            minute_prescale_next = prescale_sum[PRESCALE_W-1:0];
          end
          if (count_dec) begin
            remaining_count_next = remaining_count - 8'd1;
            // Expiry: the count steps from one to zero.
            if (remaining_count == 8'd1) begin
              if (event_reboot) begin
                reset_fire = 1'b1;
              end else if (irq_select != 4'd0) begin
                irq_fire = 1'b1;
              end
            end
          end
        end
      end
      default: ;
    endcase
  end

  assign rsp.read_data  = read_data;
  assign rsp.irq_fire   = irq_fire;
  assign rsp.reset_fire = reset_fire;
  assign rsp.irq_line   = irq_select_next;

  // State update, one word per step.
  always_ff @(posedge clk) begin
    if (rst) begin
      config_open     <= 1'b0;
      reg_index       <= 8'h00;
      logical_device  <= 8'h00;
      timer_active    <= 1'b0;
      event_reboot    <= 1'b0;
      unit_seconds    <= 1'b0;
      irq_select      <= 4'd0;
      remaining_count <= 8'h00;
      minute_prescale <= '0;
    end else if (step) begin
      config_open     <= config_open_next;
      reg_index       <= reg_index_next;
      logical_device  <= logical_device_next;
      timer_active    <= timer_active_next;
      event_reboot    <= event_reboot_next;
      unit_seconds    <= unit_seconds_next;
      irq_select      <= irq_select_next;
      remaining_count <= remaining_count_next;
      minute_prescale <= minute_prescale_next;
    end
  end

endmodule

>>> src/swt_checker.sv
`timescale 1ns / 1ps
`include "superio_watchdog_timer_top_assert.svh"

module swt_checker import swt_pkg::*; (
  input logic clk,
  input logic rst,
  input logic req_valid,
  input logic req_stall,
  input req_t req,
  input logic rsp_valid,
  input logic rsp_stall,
  input rsp_t rsp
);

  // The result channel is empty right after reset.
  `SWT_CHECK_ALWAYS(a_idle_after_reset, rst |=> !rsp_valid, "result valid after reset")

  // A word cannot expire both ways at once.
  `SWT_CHECK(a_one_pulse, rsp_valid |-> !(rsp.irq_fire && rsp.reset_fire), "both pulses set")

  // An interrupt pulse always names a line.
  `SWT_CHECK(a_irq_line, (rsp_valid && rsp.irq_fire) |-> (rsp.irq_line != 4'd0), "irq without line")

  // A fresh result follows an accepted request through the request register.
  `SWT_CHECK(a_rsp_cause, ($rose(rsp_valid) && !$past(rst) && !$past(rst, 2)) |-> $past(req_valid && !req_stall, 2), "result without request")

endmodule

bind superio_watchdog_timer_top swt_checker u_swt_checker (
  .clk       (clk),
  .rst       (rst),
  .req_valid (req_valid),
  .req_stall (req_stall),
  .req       (req),
  .rsp_valid (rsp_valid),
  .rsp_stall (rsp_stall),
  .rsp       (rsp)
);

>>> test/superio_watchdog_timer_top_test.sv
`timescale 1ns / 1ps

module superio_watchdog_timer_top_test;
  import swt_pkg::*;

  localparam int IDLE_LIMIT   = 4000;
  localparam int RANDOM_WORDS = 1200;
  localparam int SETTLE       = 16;
  localparam bit CHK          = 1'b1;
  localparam bit PRD          = 1'b0;

  // One row of the directed table: the request word and, where it is obvious,
  // the result word that it must produce.
  typedef struct packed {
    logic [1:0] op;
    logic       port;
    logic [7:0] data;
    logic       typed;
    logic [7:0] rd;
    logic       irqf;
    logic       rstf;
    logic [3:0] line;
  } row_t;

  logic clk       = 1'b0;
  logic rst       = 1'b1;
  logic req_valid = 1'b0;
  logic req_stall;
  req_t req       = '0;
  logic rsp_valid;
  logic rsp_stall = 1'b0;
  rsp_t rsp;

  // Expectation attached to the word being offered.
  logic row_typed = 1'b0;
  rsp_t row_exp   = '0;

  // Shadow copy of the watchdog state.
  logic       mode_open     = 1'b0;
  logic [7:0] sel_index     = 8'h00;
  logic [7:0] sel_device    = 8'h00;
  logic       wd_enabled    = 1'b0;
  logic       wd_reboot     = 1'b0;
  logic       wd_in_seconds = 1'b0;
  logic [3:0] wd_irq_line   = 4'h0;
  logic [7:0] wd_left       = 8'h00;
  logic [5:0] wd_subcount   = 6'h00;

  rsp_t due_results[$];
  req_t stim_q[$];
  int   errors      = 0;
  int   idle_cycles = 0;
  int   burst_left  = 0;
  int   stall_mode  = 0;
  int   stall_left  = 0;
  int   stall_phase = 0;
  bit   draining    = 1'b0;

  // Directed words: closed-mode behavior, opening twice, device select,
  // every watchdog register but the interrupt select, an expiry in reboot mode,
  // a tick at zero, an unknown register and closing again.
  row_t dir_rows [0:25] = '{
    '{OP_READ,  PORT_INDEX, 8'h00,           CHK, 8'h00, 1'b0, 1'b0, 4'h0},
    '{OP_READ,  PORT_DATA,  8'hff,           CHK, 8'h00, 1'b0, 1'b0, 4'h0},
    '{OP_WRITE, PORT_DATA,  8'hff,           CHK, 8'h00, 1'b0, 1'b0, 4'h0},
    '{OP_WRITE, PORT_INDEX, IDX_LDN,         CHK, 8'h00, 1'b0, 1'b0, 4'h0},
    '{OP_NONE,  PORT_DATA,  8'hff,           CHK, 8'h00, 1'b0, 1'b0, 4'h0},
    '{OP_WRITE, PORT_INDEX, KEY_OPEN,        PRD, 8'h00, 1'b0, 1'b0, 4'h0},
    '{OP_WRITE, PORT_INDEX, KEY_OPEN,        PRD, 8'h00, 1'b0, 1'b0, 4'h0},
    '{OP_READ,  PORT_INDEX, 8'h00,           CHK, 8'h00, 1'b0, 1'b0, 4'h0},
    '{OP_WRITE, PORT_INDEX, IDX_LDN,         PRD, 8'h00, 1'b0, 1'b0, 4'h0},
    '{OP_WRITE, PORT_DATA,  WATCHDOG_DEVICE, PRD, 8'h00, 1'b0, 1'b0, 4'h0},
    '{OP_READ,  PORT_DATA,  8'h00,           CHK, 8'h08, 1'b0, 1'b0, 4'h0},
    '{OP_WRITE, PORT_INDEX, IDX_ACTIVE,      PRD, 8'h00, 1'b0, 1'b0, 4'h0},
    '{OP_WRITE, PORT_DATA,  8'hff,           PRD, 8'h00, 1'b0, 1'b0, 4'h0},
    '{OP_READ,  PORT_DATA,  8'h00,           CHK, 8'h01, 1'b0, 1'b0, 4'h0},
    '{OP_WRITE, PORT_INDEX, IDX_EVENT,       PRD, 8'h00, 1'b0, 1'b0, 4'h0},
    '{OP_WRITE, PORT_DATA,  8'hff,           PRD, 8'h00, 1'b0, 1'b0, 4'h0},
    '{OP_WRITE, PORT_INDEX, IDX_UNIT,        PRD, 8'h00, 1'b0, 1'b0, 4'h0},
    '{OP_WRITE, PORT_DATA,  8'h80,           PRD, 8'h00, 1'b0, 1'b0, 4'h0},
    '{OP_WRITE, PORT_INDEX, IDX_TIMEOUT,     PRD, 8'h00, 1'b0, 1'b0, 4'h0},
    '{OP_WRITE, PORT_DATA,  8'h01,           PRD, 8'h00, 1'b0, 1'b0, 4'h0},
    '{OP_TICK,  PORT_INDEX, 8'h00,           CHK, 8'h00, 1'b0, 1'b1, 4'h0},
    '{OP_TICK,  PORT_DATA,  8'hff,           CHK, 8'h00, 1'b0, 1'b0, 4'h0},
    '{OP_WRITE, PORT_INDEX, 8'h00,           PRD, 8'h00, 1'b0, 1'b0, 4'h0},
    '{OP_READ,  PORT_DATA,  8'h00,           CHK, 8'h00, 1'b0, 1'b0, 4'h0},
    '{OP_WRITE, PORT_INDEX, KEY_CLOSE,       PRD, 8'h00, 1'b0, 1'b0, 4'h0},
    '{OP_READ,  PORT_INDEX, 8'h00,           CHK, 8'h00, 1'b0, 1'b0, 4'h0}
  };

  superio_watchdog_timer_top DUT (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

  always #4 clk = ~clk;

  // Data-port read of the selected register, with only its defined bits.
  function automatic logic [7:0] read_selected();
    if (sel_index == IDX_LDN) return sel_device;
    if (sel_device != WATCHDOG_DEVICE) return 8'h00;
    case (sel_index)
      IDX_ACTIVE:  return {7'b0, wd_enabled};
      IDX_EVENT:   return {4'b0, wd_reboot, 3'b0};
      IDX_UNIT:    return {wd_in_seconds, 7'b0};
      IDX_TIMEOUT: return wd_left;
      IDX_IRQSEL:  return {wd_irq_line, 4'b0};
      default:     return 8'h00;
    endcase
  endfunction

  // Data-port write to the selected register.
  function automatic void write_selected(logic [7:0] v);
    if (sel_index == IDX_LDN) begin
      sel_device = v;
    end else if (sel_device == WATCHDOG_DEVICE) begin
      case (sel_index)
        IDX_ACTIVE:  wd_enabled = v[0];
        IDX_EVENT:   wd_reboot = v[3];
        IDX_UNIT:    wd_in_seconds = v[7];
        IDX_TIMEOUT: begin
          wd_left = v;
          wd_subcount = '0;
        end
        IDX_IRQSEL:  wd_irq_line = v[7:4];
        default: ;
      endcase
    end
  endfunction

  // Advances the shadow state by one request word and returns its result word.
  function automatic rsp_t step_watchdog(req_t w);
    rsp_t       r;
    logic       dec;
    logic [6:0] sub_next;
    r = '0;
    dec = 1'b0;
    case (opcode_t'(w.opcode))
      OP_WRITE: begin
        if (w.port_select == PORT_INDEX) begin
          if (w.write_data == KEY_OPEN) mode_open = 1'b1;
          else if (mode_open) begin
            if (w.write_data == KEY_CLOSE) mode_open = 1'b0;
            else sel_index = w.write_data;
          end
        end else if (mode_open) begin
          write_selected(w.write_data);
        end
      end
      OP_READ: begin
        if (mode_open)
          r.read_data = (w.port_select == PORT_INDEX) ? sel_index : read_selected();
      end
      OP_TICK: begin
        if (wd_enabled && wd_left != 8'h00) begin
          if (wd_in_seconds) begin
            dec = 1'b1;
          end else begin
            sub_next = {1'b0, wd_subcount} + 7'd1;
            if (sub_next >= TICKS_PER_MINUTE) begin
              wd_subcount = '0;
              dec = 1'b1;
            end else begin
              wd_subcount = sub_next[5:0];
            end
          end
          if (dec) begin
            wd_left = wd_left - 8'd1;
            if (wd_left == 8'h00) begin
              if (wd_reboot) r.reset_fire = 1'b1;
              else if (wd_irq_line != 4'h0) r.irq_fire = 1'b1;
            end
          end
        end
      end
      default: ;
    endcase
    r.irq_line = wd_irq_line;
    return r;
  endfunction

  function automatic logic [7:0] any_byte();
    return 8'($urandom_range(0, 255));
  endfunction

  function automatic logic any_port();
    return 1'($urandom_range(0, 1));
  endfunction

  task automatic put(opcode_t op, logic port, logic [7:0] data);
    req_t w;
    w.opcode      = op;
    w.port_select = port;
    w.write_data  = data;
    stim_q.push_back(w);
  endtask

  task automatic put_reg(logic [7:0] idx, logic [7:0] val);
    put(OP_WRITE, PORT_INDEX, idx);
    put(OP_WRITE, PORT_DATA, val);
  endtask

  // A full timer setup followed by ticks, enough to reach expiry for loads up
  // to 12, mostly in seconds and now and then in minutes, with reads mixed in.
  task automatic add_timer_run();
    logic       minute_unit;
    logic [7:0] b;
    logic [7:0] load;
    int         ticks;
    minute_unit = ($urandom_range(0, 11) == 0);
    put(OP_WRITE, PORT_INDEX, KEY_OPEN);
    put_reg(IDX_LDN, ($urandom_range(0, 7) == 0) ? any_byte() : WATCHDOG_DEVICE);
    put_reg(IDX_EVENT, any_byte());
    b = any_byte();
    if ($urandom_range(0, 4) == 0) b[7:4] = 4'h0;
    put_reg(IDX_IRQSEL, b);
    b = any_byte();
    b[7] = ~minute_unit;
    put_reg(IDX_UNIT, b);
    b = any_byte();
    if ($urandom_range(0, 7) != 0) b[0] = 1'b1;
    put_reg(IDX_ACTIVE, b);
    if (minute_unit) load = 8'($urandom_range(1, 2));
    else if ($urandom_range(0, 9) == 0) load = any_byte();
    else load = 8'($urandom_range(0, 6));
    put_reg(IDX_TIMEOUT, load);
    if ($urandom_range(0, 1) == 1) put(OP_WRITE, PORT_INDEX, KEY_CLOSE);
    if (minute_unit) ticks = load * TICKS_PER_MINUTE + $urandom_range(0, 3);
    else ticks = ((load > 12) ? 12 : load) + $urandom_range(0, 3);
    repeat (ticks) begin
      put(OP_TICK, any_port(), any_byte());
      if ($urandom_range(0, 5) == 0) put(OP_READ, any_port(), any_byte());
    end
  endtask

  // Register accesses through both ports with random indexes and data.
  task automatic add_register_mix();
    logic [7:0] idx;
    if ($urandom_range(0, 3) != 0) put(OP_WRITE, PORT_INDEX, KEY_OPEN);
    repeat ($urandom_range(3, 10)) begin
      case ($urandom_range(0, 6))
        0:       idx = IDX_LDN;
        1:       idx = IDX_ACTIVE;
        2:       idx = IDX_EVENT;
        3:       idx = IDX_UNIT;
        4:       idx = IDX_TIMEOUT;
        5:       idx = IDX_IRQSEL;
        default: idx = any_byte();
      endcase
      put(OP_WRITE, PORT_INDEX, idx);
      case ($urandom_range(0, 2))
        0: put(OP_WRITE, PORT_DATA,
               (idx == IDX_LDN && $urandom_range(0, 3) != 0) ? WATCHDOG_DEVICE : any_byte());
        1: put(OP_READ, PORT_DATA, any_byte());
        default: put(OP_READ, PORT_INDEX, any_byte());
      endcase
    end
  endtask

  // Unstructured words of every opcode, often with the mode closed first.
  task automatic add_noise();
    if ($urandom_range(0, 1) == 1) put(OP_WRITE, PORT_INDEX, KEY_CLOSE);
    repeat ($urandom_range(4, 16))
      put(opcode_t'($urandom_range(0, 3)), any_port(), any_byte());
  endtask

  // Offers one word in bursts with random gaps and returns at the edge
  // where it is accepted.
  task automatic send(req_t w, logic typed, rsp_t exp);
    int gap;
    @(negedge clk);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = $urandom_range(0, 5);
      if (gap != 0) begin
        req_valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    burst_left--;
    req_valid <= 1'b1;
    req       <= w;
    row_typed <= typed;
    row_exp   <= exp;
    do @(posedge clk); while (req_stall);
  endtask

  // Holds the sender off until every expected result word has arrived.
  task automatic pause_until_drained();
    @(negedge clk);
    req_valid <= 1'b0;
    while (due_results.size() != 0) @(posedge clk);
  endtask

  // Receiver stall, switching among its own patterns, released at the end.
  always @(negedge clk) begin
    if (rst || draining) begin
      rsp_stall <= 1'b0;
    end else begin
      if (stall_left == 0) begin
        stall_mode = $urandom_range(0, 3);
        stall_left = $urandom_range(16, 80);
      end
      stall_left--;
      stall_phase++;
      case (stall_mode)
        0:       rsp_stall <= 1'b0;
        1:       rsp_stall <= ($urandom_range(0, 3) == 0);
        2:       rsp_stall <= ($urandom_range(0, 3) != 0);
        default: rsp_stall <= (stall_phase % 8 >= 5);
      endcase
    end
  end

  // Prediction on every accepted request word and checking of every
  // accepted result word against the oldest expectation.
  always @(posedge clk) begin : scoreboard
    rsp_t want;
    rsp_t got;
    if (!rst) begin
      if (req_valid && !req_stall) begin
        want = step_watchdog(req);
        due_results.push_back(row_typed ? row_exp : want);
      end
      if (rsp_valid && !rsp_stall) begin
        got = rsp;
        if (due_results.size() == 0) begin
          errors++;
          if (errors <= 10)
            $display("%0t: result word with nothing expected: %s%h irq=%b reset=%b line=%h",
                     $realtime, "read=", got.read_data, got.irq_fire,
                     got.reset_fire, got.irq_line);
        end else begin
          want = due_results.pop_front();
          if (got.read_data !== want.read_data || got.irq_fire !== want.irq_fire ||
              got.reset_fire !== want.reset_fire || got.irq_line !== want.irq_line) begin
            errors++;
            if (errors <= 10)
              $display({"%0t: mismatch: expected read=%h irq=%b reset=%b line=%h, ",
                        "got read=%h irq=%b reset=%b line=%h"},
                       $realtime, want.read_data, want.irq_fire, want.reset_fire,
                       want.irq_line, got.read_data, got.irq_fire, got.reset_fire,
                       got.irq_line);
          end
        end
      end
    end
  end

  // Ends the run when neither channel moves a word for too long.
  always @(posedge clk) begin
    if (rst || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("superio_watchdog_timer_top_test: done, errors");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Reset, the directed table, then the random words, then the drain.
  initial begin : stimulus
    req_t w;
    rsp_t e;
    row_t r;
    int   i;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (dir_rows[k]) begin
      r             = dir_rows[k];
      w.opcode      = r.op;
      w.port_select = r.port;
      w.write_data  = r.data;
      e.read_data   = r.rd;
      e.irq_fire    = r.irqf;
      e.reset_fire  = r.rstf;
      e.irq_line    = r.line;
      send(w, r.typed, e);
    end
    pause_until_drained();

    while (stim_q.size() < RANDOM_WORDS) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4: add_timer_run();
        5, 6, 7:       add_register_mix();
        default:       add_noise();
      endcase
    end
    for (i = 0; i < stim_q.size(); i++) begin
      if (i == stim_q.size() / 2) pause_until_drained();
      send(stim_q[i], PRD, '0);
    end

    @(negedge clk);
    req_valid <= 1'b0;
    draining = 1'b1;
    while (due_results.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    if (errors == 0)
      $display("superio_watchdog_timer_top_test: done, clean");
    else
      $display("superio_watchdog_timer_top_test: done, errors");
    $finish;
  end

endmodule

>>> superio_watchdog_timer_top.f
+incdir+src
src/swt_pkg.sv
src/swt_core.sv
src/superio_watchdog_timer_top.sv
src/swt_checker.sv
test/superio_watchdog_timer_top_test.sv
